// ===== rtl/laplacian_sharpen_3x3_top_macros.svh =====
// ----------------------------------------------------------------------------
// Laplacian sharpen assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_3X3_TOP_MACROS_SVH
`define LAPLACIAN_SHARPEN_3X3_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// Laplacian sharpen package
// Shared constants, register codes and control types of the sharpen block.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int LSH_MAX_WIDTH = 2048;
    localparam int PIX_W         = 8;
    localparam int CFG_W_WIDTH   = 12;
    localparam int CFG_H_WIDTH   = 16;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int CENTER_GAIN   = 5;

    localparam logic [CFG_W_WIDTH-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_H_WIDTH-1:0] HEIGHT_RESET = 16'd480;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Line store access: en strobes a read of both banks and a write,
    // wsel picks the bank that takes the incoming row.
    typedef struct packed {
        logic en;
        logic wsel;
    } t_mem_ctl;

endpackage

// ===== rtl/lsh_ifs.sv =====
// ----------------------------------------------------------------------------
// Laplacian sharpen stream interfaces
// Valid/ready channels for input pixel transactions and output results.
// ----------------------------------------------------------------------------
interface lsh_in_if;
    import lsh_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output func, output pixel_in, input ready);
    modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface lsh_out_if;
    import lsh_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output pixel_out, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                    output ready);
endinterface

// ===== rtl/lsh_line_store.sv =====
// ----------------------------------------------------------------------------
// Laplacian sharpen line store
// Two row banks, one read port each with registered data, one shared write.
// ----------------------------------------------------------------------------
module lsh_line_store #(
    parameter int  MAX_WIDTH = lsh_pkg::LSH_MAX_WIDTH,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                      i_clk,
    input  lsh_pkg::t_mem_ctl         i_ctl,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lsh_pkg::PIX_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr0,
    input  logic [AW-1:0]             i_raddr1,
    output logic [lsh_pkg::PIX_W-1:0] o_rdata0,
    output logic [lsh_pkg::PIX_W-1:0] o_rdata1
);
    import lsh_pkg::*;

    logic [PIX_W-1:0] r_mem0 [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem1 [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd0;
    logic [PIX_W-1:0] r_rd1;

    // Read returns the old entry when the same address is written.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rd0 <= r_mem0[i_raddr0];
            if (!i_ctl.wsel) begin
                r_mem0[i_waddr] <= i_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rd1 <= r_mem1[i_raddr1];
            if (i_ctl.wsel) begin
                r_mem1[i_waddr] <= i_wdata;
            end
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

// ===== rtl/laplacian_sharpen_3x3_top.sv =====
// ----------------------------------------------------------------------------
// Laplacian sharpen 3x3 top level
// Raster-order 8-bit pixel stream in, 5*centre minus four neighbours out.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per pixel (func = 0) or drain (func = 1).
//   o_out carries one result per pixel of rows 1 and up, describing the
//   pixel one row above; after the last input row, image_width drains push
//   out the final all-zero row, the last one flagged with frame_end.
//   Border pixels (first/last row and column) come out as zero.
//   The APB port holds image_width (0x0) and image_height (0x4); a write
//   restarts the frame. Write only while the stream is idle.
// Throughput and timing:
//   One transaction per cycle sustained unless o_out stalls. A result
//   sits in the output register in the cycle after its transaction is
//   accepted. The rate is set by the line store: each bank does one
//   read per accepted pixel, and the previous-row stream is fetched two
//   columns ahead so that each pixel finds its window already registered.
// Reset and stall:
//   Reset clears the counters and loads 640 x 480; the line store is not
//   cleared (only rows of the current frame are ever used).
//   While o_out is stalled with a result pending, i_in.ready drops; it
//   rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
`include "laplacian_sharpen_3x3_top_macros.svh"

module laplacian_sharpen_3x3_top #(
    parameter int MAX_WIDTH = lsh_pkg::LSH_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lsh_in_if.sink                     i_in,
    lsh_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lsh_pkg::APB_AW-1:0] paddr,
    input  logic [lsh_pkg::APB_DW-1:0] pwdata,
    output logic [lsh_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import lsh_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > CFG_W_WIDTH) ? WW : CFG_W_WIDTH;
    localparam int SUMW = PIX_W + 4;

    // Configuration
    logic [CFG_W_WIDTH-1:0] r_img_w;
    logic [CFG_H_WIDTH-1:0] r_img_h;
    logic                   cfg_wr;
    t_reg_idx               cfg_idx;
    logic [WW-1:0]          eff_w;
    logic [CFG_H_WIDTH-1:0] eff_h;

    // Frame position
    logic [CFG_H_WIDTH-1:0] r_row,   n_row;
    logic [AW-1:0]          r_col,   n_col;
    logic [WW-1:0]          r_drain, n_drain;

    // Window registers (previous row, left and centre) and stream source
    logic [PIX_W-1:0]       r_left;
    logic [PIX_W-1:0]       r_ctr;
    logic                   r_psrc,  n_psrc;

    // Output register
    logic                   r_ov;
    logic [PIX_W-1:0]       r_pix;
    logic                   r_re;
    logic                   r_fe;

    logic                   in_ready;
    logic                   in_acc;
    logic                   frame_done;
    logic                   drain_live;
    logic                   drain_last;
    logic                   pix_acc;
    logic                   drn_acc;
    logic                   produce;
    logic [CFG_H_WIDTH-1:0] row_eff;
    logic [AW-1:0]          col_eff;
    logic [WW-1:0]          col_p1;
    logic                   last_col;
    logic                   near_end;
    logic                   interior;
    logic                   parity;
    logic [AW-1:0]          p_addr;
    logic [AW-1:0]          q_addr;
    logic [PIX_W-1:0]       rd0, rd1;
    logic [PIX_W-1:0]       px_right, px_up;
    logic [SUMW-1:0]        acc;
    logic [PIX_W-1:0]       sat;
    t_mem_ctl               mem_ctl;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_RESET;
            r_img_h <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:  r_img_w <= pwdata[CFG_W_WIDTH-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= pwdata[CFG_H_WIDTH-1:0];
                default:          r_img_w <= r_img_w;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_img_w);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_img_h);
            default:          prdata = '0;
        endcase
    end

    // Clamp width to 1..MAX_WIDTH, height to at least 1
    always_comb begin
        if (r_img_w == '0) begin
            eff_w = WW'(1);
        end else if (CMPW'(r_img_w) > CMPW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_img_w);
        end
    end

    assign eff_h = (r_img_h == '0) ? CFG_H_WIDTH'(1) : r_img_h;

    // ------------------------------------------------------------------
    // Transaction decode
    // ------------------------------------------------------------------
    assign in_ready   = !r_ov || o_out.ready;
    assign in_acc     = i_in.valid && in_ready;
    assign frame_done = (r_row >= eff_h);
    assign drain_live = frame_done && (r_drain < eff_w);
    assign drain_last = ((r_drain + WW'(1)) >= eff_w);
    assign pix_acc    = in_acc && !i_in.func;
    assign drn_acc    = in_acc && i_in.func && drain_live;

    // A pixel after the frame is complete starts a new frame at (0,0)
    assign row_eff  = frame_done ? '0 : r_row;
    assign col_eff  = frame_done ? '0 : r_col;
    assign col_p1   = WW'(col_eff) + WW'(1);
    assign last_col = (col_p1 >= eff_w);
    assign near_end = ((WW'(col_eff) + WW'(2)) == eff_w);
    assign interior = (row_eff >= CFG_H_WIDTH'(2)) && (col_eff != '0) && (col_p1 < eff_w);
    assign parity   = row_eff[0];
    assign produce  = (pix_acc && (row_eff != '0)) || drn_acc;

    // ------------------------------------------------------------------
    // Line store: bank[parity] takes row r and still holds row r-2;
    // the other bank holds row r-1. The row r-1 stream runs two columns
    // ahead; near the row end it switches to the bank being written,
    // which becomes the previous row of the next line.
    // ------------------------------------------------------------------
    assign p_addr = col_eff + AW'(2);

    always_comb begin
        if (last_col) begin
            q_addr = AW'(1);
            n_psrc = parity;
        end else if (near_end) begin
            q_addr = '0;
            n_psrc = parity;
        end else begin
            q_addr = col_eff + AW'(1);
            n_psrc = !parity;
        end
    end

    assign mem_ctl.en   = pix_acc;
    assign mem_ctl.wsel = parity;

    lsh_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_ctl    (mem_ctl),
        .i_waddr  (col_eff),
        .i_wdata  (i_in.pixel_in),
        .i_raddr0 (parity ? p_addr : q_addr),
        .i_raddr1 (parity ? q_addr : p_addr),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    assign px_right = r_psrc ? rd1 : rd0;
    assign px_up    = parity ? rd1 : rd0;

    // Advance the window on every accepted pixel
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_left <= r_ctr;
            r_ctr  <= px_right;
            r_psrc <= n_psrc;
        end
    end

    // ------------------------------------------------------------------
    // Kernel: 5*centre - left - right - up - down, saturate to 0..255
    // ------------------------------------------------------------------
    always_comb begin
        acc = SUMW'(CENTER_GAIN * r_ctr) - SUMW'(r_left) - SUMW'(px_right)
            - SUMW'(px_up) - SUMW'(i_in.pixel_in);
        if (acc[SUMW-1]) begin
            sat = '0;
        end else if (|acc[SUMW-2:PIX_W]) begin
            sat = '1;
        end else begin
            sat = acc[PIX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Row, column and drain counters
    // ------------------------------------------------------------------
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_drain = r_drain;
        if (cfg_wr) begin
            n_row   = '0;
            n_col   = '0;
            n_drain = '0;
        end else if (drn_acc) begin
            if (drain_last) begin
                n_row   = '0;
                n_col   = '0;
                n_drain = '0;
            end else begin
                n_drain = r_drain + WW'(1);
            end
        end else if (pix_acc) begin
            n_drain = frame_done ? '0 : r_drain;
            if (last_col) begin
                n_col   = '0;
                n_row   = row_eff + CFG_H_WIDTH'(1);
                n_drain = '0;
            end else begin
                n_col = col_eff + AW'(1);
                n_row = row_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= '0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_drain <= n_drain;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on a producing transaction, drop when taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (produce) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            if (drn_acc) begin
                r_pix <= '0;
                r_re  <= drain_last;
                r_fe  <= drain_last;
            end else begin
                r_pix <= interior ? sat : '0;
                r_re  <= last_col;
                r_fe  <= 1'b0;
            end
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_ov;
    assign o_out.pixel_out = r_pix;
    assign o_out.row_end   = r_re;
    assign o_out.frame_end = r_fe;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LSH_ASSERT_SAME(a_col_in_row, 1'b1, WW'(r_col) < eff_w, "column beyond row width")
    `LSH_ASSERT_SAME(a_row_bound, 1'b1, r_row <= eff_h, "row count beyond frame height")
    `LSH_ASSERT_SAME(a_drain_phase, r_drain != '0, r_row == eff_h, "drain outside drain phase")
    `LSH_ASSERT_SAME(a_fe_is_re, r_ov && r_fe, r_re, "frame end without row end")
    `LSH_ASSERT_NEXT(a_result_loaded, produce, r_ov, "result lost after transaction")

endmodule
